[src/pes_pkg.sv]
// Shared types and constants for the product-except-self unit.
`timescale 1ns / 1ps

package pes_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic load;
    logic back_rd;
    logic back_mul;
    logic fwd_mul;
  } pes_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_last;
  } pes_stat_t;

endpackage

[src/pes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pes_ctrl.sv]
// Controller state machine sequencing load, backward pass and emit pass.
`timescale 1ns / 1ps

module pes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_in_i,
  input  pes_pkg::pes_stat_t stat_i,
  output pes_pkg::pes_cmd_t  cmd_o,
  output logic              busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BRD  = 3'd1;
  localparam logic [2:0] S_BMUL = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FMUL = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_in_i) begin
            state_d = S_BRD;
          end
        end
      end
      S_BRD: begin
        cmd_o.back_rd = 1'b1;
        state_d       = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.back_mul = 1'b1;
        state_d        = stat_i.idx_zero ? S_FRD : S_BRD;
      end
      S_FRD: begin
        state_d = S_FMUL;
      end
      S_FMUL: begin
        cmd_o.fwd_mul = 1'b1;
        state_d       = stat_i.idx_last ? S_IDLE : S_FRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/pes_dp.sv]
// Datapath: element, prefix and suffix stores, running products and result register.
`timescale 1ns / 1ps

module pes_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pes_pkg::pes_cmd_t                 cmd_i,
  input  logic [pes_pkg::DATA_W-1:0]       value_i,
  input  logic                             last_in_i,
  output pes_pkg::pes_stat_t                stat_o,
  output logic [pes_pkg::DATA_W-1:0]       product_o,
  output logic                             last_out_o,
  output logic                             strobe_o
);

  localparam int unsigned W  = pes_pkg::DATA_W;
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [W-1:0]  run_q, run_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  prod_q, prod_d;
  logic          strobe_q, strobe_d;
  logic          last_q, last_d;

  logic          store;
  logic          load_we;
  logic          suf_we;
  logic [W-1:0]  elem_rd, pre_rd, suf_rd;
  logic [W-1:0]  run_mul, acc_mul, prod_mul;

  assign store   = (count_q < CW'(MAX_ITEMS));
  assign load_we = cmd_i.load & store;
  assign suf_we  = cmd_i.back_rd;

  assign run_mul  = run_q * value_i;
  assign acc_mul  = acc_q * elem_rd;
  assign prod_mul = pre_rd * suf_rd;

  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.idx_last = ((CW'(idx_q) + CW'(1)) == count_q);

  pes_ram #(.WIDTH(W), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (idx_q),
    .rdata_o (elem_rd)
  );

  pes_ram #(.WIDTH(W), .DEPTH(MAX_ITEMS)) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (run_q),
    .raddr_i (idx_q),
    .rdata_o (pre_rd)
  );

  pes_ram #(.WIDTH(W), .DEPTH(MAX_ITEMS)) u_suffix_ram (
    .clk_i   (clk_i),
    .we_i    (suf_we),
    .waddr_i (idx_q),
    .wdata_i (acc_q),
    .raddr_i (idx_q),
    .rdata_o (suf_rd)
  );

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    run_d    = run_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    strobe_d = 1'b0;
    last_d   = last_q;
    if (cmd_i.load) begin
      if (store) begin
        run_d   = run_mul;
        count_d = count_q + CW'(1);
      end
      if (last_in_i) begin
        run_d = W'(1);
        acc_d = W'(1);
        idx_d = store ? count_q[AW-1:0] : AW'(MAX_ITEMS - 1);
      end
    end
    if (cmd_i.back_mul) begin
      acc_d = acc_mul;
      if (!stat_o.idx_zero) begin
        idx_d = idx_q - AW'(1);
      end
    end
    if (cmd_i.fwd_mul) begin
      prod_d   = prod_mul;
      strobe_d = 1'b1;
      last_d   = stat_o.idx_last;
      if (stat_o.idx_last) begin
        count_d = '0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      run_q    <= W'(1);
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      run_q    <= run_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    last_q <= last_d;
  end

  assign product_o  = prod_q;
  assign last_out_o = last_q;
  assign strobe_o   = strobe_q;

endmodule

[src/product_except_self_unit.sv]
// Top level of the product-except-self unit.
`timescale 1ns / 1ps
// Usage: elements of a set arrive one item at a time on value_i with last_in_i
// marking the final element. An item is taken on a clock edge where start_i is
// high and busy_o is low. For unmarked items busy_o stays low. After the marked
// item the block raises busy_o, runs a backward pass over the stored elements
// (each element: a registered element store read, then the suffix multiplier),
// then an emit pass (each element: registered prefix and suffix store reads,
// then the output multiplier). Each result appears on product_o and last_out_o
// with strobe_o high for exactly one cycle; last_out_o marks the final result
// of the set. Elements beyond MAX_ITEMS are dropped, though a dropped marked
// item still ends the set. The receiver cannot stall the results. Reset clears
// the element count, sets the running product to one and returns to idle.

module product_except_self_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] value_i,
  input  logic               last_in_i,
  output logic signed [31:0] product_o,
  output logic               last_out_o,
  output logic               strobe_o
);

  pes_pkg::pes_cmd_t  cmd;
  pes_pkg::pes_stat_t stat;
  logic [pes_pkg::DATA_W-1:0] product;

  pes_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .last_in_i (last_in_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  pes_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .last_in_i  (last_in_i),
    .stat_o     (stat),
    .product_o  (product),
    .last_out_o (last_out_o),
    .strobe_o   (strobe_o)
  );

  assign product_o = $signed(product);

`ifndef SYNTHESIS
  // An unmarked item never makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_in_i) |=> !busy_o)
    else $error("busy after unmarked item");

  // A marked item starts the passes and no result appears in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_in_i) |=> (busy_o && !strobe_o))
    else $error("marked item did not start passes");

  // The final result of a set is followed by an idle output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_out_o) |=> !strobe_o)
    else $error("result after final result");

  // Results other than the final one occur only while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_out_o) |-> busy_o)
    else $error("result strobe while idle");
`endif

endmodule

[verif/tb_product_except_self_unit.sv]
// Self-checking testbench for the product-except-self unit with a scoreboard class.
`timescale 1ns / 1ps

module tb_product_except_self_unit;

  localparam int unsigned DATA_W       = pes_pkg::DATA_W;
  localparam int unsigned SET_DEPTH    = 64;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned QUIET_ITEMS  = 60;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct {
    logic [DATA_W-1:0] product;
    logic              last;
  } product_entry_t;

  class except_product_board;
    logic [DATA_W-1:0] elements [SET_DEPTH];
    logic [DATA_W-1:0] prefixes [SET_DEPTH];
    logic [DATA_W-1:0] running;
    int unsigned       stored;
    product_entry_t    pending_products [$];
    int unsigned       failures;
    int unsigned       results_seen;

    function new();
      running      = 1;
      stored       = 0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void report(string what, logic [DATA_W-1:0] exp_p, logic exp_l,
                         logic [DATA_W-1:0] act_p, logic act_l);
      failures++;
      if (failures <= REPORT_MAX) begin
        $display("mismatch (%s): expected product %0d last %0b, got product %0d last %0b",
                 what, $signed(exp_p), exp_l, $signed(act_p), act_l);
      end
    endfunction

    function void take_element(logic [DATA_W-1:0] value, logic last);
      logic [DATA_W-1:0] suffix;
      if (stored < SET_DEPTH) begin
        elements[stored] = value;
        prefixes[stored] = running;
        running = running * value;
        stored++;
      end
      if (last) begin
        product_entry_t ent;
        logic [DATA_W-1:0] suffixes [SET_DEPTH];
        suffix = 1;
        for (int i = int'(stored) - 1; i >= 0; i--) begin
          suffixes[i] = suffix;
          suffix = suffix * elements[i];
        end
        for (int unsigned i = 0; i < stored; i++) begin
          ent.product = prefixes[i] * suffixes[i];
          ent.last    = (i + 1 == stored);
          pending_products.push_back(ent);
        end
        stored  = 0;
        running = 1;
      end
    endfunction

    function void check_product(logic [DATA_W-1:0] product, logic last);
      product_entry_t ent;
      results_seen++;
      if (pending_products.size() == 0) begin
        report("unexpected result", '0, 1'b0, product, last);
      end else begin
        ent = pending_products.pop_front();
        if (ent.product !== product || ent.last !== last) begin
          report("wrong field", ent.product, ent.last, product, last);
        end
      end
    endfunction

    function void close();
      while (pending_products.size() > 0) begin
        product_entry_t ent;
        ent = pending_products.pop_front();
        report("missing result", ent.product, ent.last, 'x, 1'bx);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [DATA_W-1:0] value_i;
  logic                     last_in_i;
  logic signed [DATA_W-1:0] product_o;
  logic                     last_out_o;
  logic                     strobe_o;

  except_product_board board;
  int unsigned         cycle_count = 0;
  int unsigned         items_sent  = 0;
  int unsigned         sets_sent   = 0;
  int unsigned         overlong_sets = 0;
  int unsigned         largest_set = 0;

  product_except_self_unit #(
    .MAX_ITEMS(SET_DEPTH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .value_i   (value_i),
    .last_in_i (last_in_i),
    .product_o (product_o),
    .last_out_o(last_out_o),
    .strobe_o  (strobe_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      board.take_element(value_i, last_in_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      board.check_product(product_o, last_out_o);
    end
  end

  function automatic logic [DATA_W-1:0] draw_element();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3, 4: return DATA_W'($signed($urandom_range(0, 14)) - 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_element(input logic [DATA_W-1:0] value, input logic last);
    start_i   <= 1'b1;
    value_i   <= value;
    last_in_i <= last;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_set(input int unsigned len, input bit with_gaps);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_gaps && $urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 15));
      end
      send_element(draw_element(), i + 1 == len);
    end
    sets_sent++;
    if (len > SET_DEPTH) overlong_sets++;
    if (len > largest_set) largest_set = len;
  endtask

  initial begin
    int unsigned len;
    bit          gaps;
    board     = new();
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    value_i   = '0;
    last_in_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed sets; the single-element ones must give the empty product.
    send_element(32'h7fff_ffff, 1'b1);
    send_element(32'h8000_0000, 1'b1);
    send_element(32'h0000_0000, 1'b1);
    send_element(32'hffff_ffff, 1'b1);
    send_element(32'h0000_0001, 1'b1);
    send_element(32'h7fff_ffff, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'hffff_ffff, 1'b1);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0000_0005, 1'b0);
    send_element(32'hffff_fff9, 1'b1);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0000_0003, 1'b1);
    send_element(32'h0001_0000, 1'b0);
    send_element(32'h0001_0000, 1'b0);
    send_element(32'h0000_0002, 1'b1);
    send_element(32'h0000_0002, 1'b0);
    send_element(32'h0000_0003, 1'b0);
    send_element(32'h0000_0004, 1'b0);
    send_element(32'h0000_0005, 1'b1);
    sets_sent += 10;
    largest_set = 4;

    pause_sender(1);
    while (board.pending_products.size() > 0) @(posedge clk_i);

    // An overlong set first, so the dropped marked item is always seen.
    send_set(SET_DEPTH + 2, 1'b0);
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 6);
        1:       len = $urandom_range(40, SET_DEPTH);
        2:       len = ($urandom_range(0, 1) != 0) ? SET_DEPTH : 1;
        default: len = $urandom_range(1, 8);
      endcase
      gaps = (items_sent + len + QUIET_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 2) != 0);
      send_set(len, gaps);
    end

    pause_sender(1);
    while (board.pending_products.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.close();

    $display("summary: %0d sets (%0d overlong, largest %0d elements), %0d results checked",
             sets_sent, overlong_sets, largest_set, board.results_seen);
    $display("summary: %0d failures over %0d cycles", board.failures, cycle_count);
    if (board.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/pes_pkg.sv
src/pes_ram.sv
src/pes_ctrl.sv
src/pes_dp.sv
src/product_except_self_unit.sv
verif/tb_product_except_self_unit.sv
